FILE: rtl/core/closest_image_mode_search_assert.svh
`ifndef CLOSEST_IMAGE_MODE_SEARCH_ASSERT_SVH
`define CLOSEST_IMAGE_MODE_SEARCH_ASSERT_SVH

// Checks on aclk, off while aresetn is low.
`define CIMS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define CIMS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cims_pkg.sv
package cims_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int DIM_BITS_DEF    = 13;
    localparam int REQ_DIM_W       = 13;
    localparam int FMT_W           = 2;
    localparam int INDEX_W         = 6;
    localparam int DIST_OUT_W      = 27;
    localparam int QUEUE_DEPTH     = 4;
    localparam int CFG_ADDR_W      = 4;
    localparam int CFG_DATA_W      = 32;
    localparam int S_TUSER_W       = 2;
    localparam int M_TUSER_W       = 2;
    localparam int M_TDATA_W       = ((INDEX_W + DIST_OUT_W + 7) / 8) * 8;

    localparam logic [1:0] REG_REQ_WIDTH  = 2'd0;
    localparam logic [1:0] REG_REQ_HEIGHT = 2'd1;
    localparam logic [1:0] REG_REQ_FORMAT = 2'd2;

    typedef struct packed {
        logic [REQ_DIM_W-1:0] req_width;
        logic [REQ_DIM_W-1:0] req_height;
        logic [FMT_W-1:0]     req_format;
    } cims_cfg_t;

    typedef struct packed {
        logic is_mode;
        logic is_match;
        logic last;
    } cims_flags_t;

    typedef struct packed {
        logic empty;
        logic full;
    } cims_qstat_t;

endpackage

FILE: rtl/core/closest_image_mode_search.sv
// Closest image mode search: takes one mode table entry per clock while s_tready is high. The
// front computes the entry area, requested area and overlap area (three DIM_BITS x DIM_BITS
// multipliers) and pushes them into a four-deep queue; the back forms the non-overlap
// distance and updates the format-matching and other-format winners with one add and
// compare per entry. The result of a table is written to an output register when the entry
// carrying tlast is popped from the queue, and waits there; s_tready drops only when the
// queue fills behind a result held by m_tready low.
`include "closest_image_mode_search_assert.svh"

module closest_image_mode_search #(
    parameter int MAX_ENTRIES = cims_pkg::MAX_ENTRIES_DEF,
    parameter int DIM_BITS    = cims_pkg::DIM_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_width, entry_height
    input  logic [((2*DIM_BITS+7)/8)*8-1:0] s_tdata,
    // entry_is_mode, entry_is_dpcm8
    input  logic [cims_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // best_index, best_distance
    output logic [cims_pkg::M_TDATA_W-1:0]  m_tdata,
    // found, format_matched
    output logic [cims_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cims_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cims_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cims_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import cims_pkg::*;

    localparam int ENT_W = 3 + $clog2(MAX_ENTRIES) + 6 * DIM_BITS;

    cims_cfg_t        cfg;
    cims_qstat_t      q_stat;
    logic             q_push, q_pop;
    logic [ENT_W-1:0] q_wdata, q_rdata;

    assign pready = 1'b1;

    cims_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    cims_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .DIM_BITS    (DIM_BITS),
        .ENT_W       (ENT_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    cims_queue #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    cims_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .DIM_BITS    (DIM_BITS),
        .ENT_W       (ENT_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rdata  (q_rdata),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `CIMS_ASSERT_IMPL(a_not_found_zero, m_tvalid && !m_tuser[0], m_tdata == '0 && !m_tuser[1], "not-found result carries data")
    `CIMS_ASSERT_IMPL(a_pop_not_empty, q_pop, !q_stat.empty, "queue popped while empty")
    `CIMS_ASSERT_NEXT(a_full_blocks, q_stat.full && !q_pop, !s_tready, "input open while queue full")

endmodule

FILE: rtl/core/cims_regs.sv
module cims_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cims_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cims_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cims_pkg::CFG_DATA_W-1:0] prdata,
    output cims_pkg::cims_cfg_t             cfg
);
    import cims_pkg::*;

    logic [REQ_DIM_W-1:0] req_width_reg, req_width_next;
    logic [REQ_DIM_W-1:0] req_height_reg, req_height_next;
    logic [FMT_W-1:0]     req_format_reg, req_format_next;
    logic                 wr_en;
    logic [1:0]           reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb begin
        req_width_next  = req_width_reg;
        req_height_next = req_height_reg;
        req_format_next = req_format_reg;
        prdata          = '0;
        unique case (reg_idx)
            REG_REQ_WIDTH: begin
                prdata = {{(CFG_DATA_W-REQ_DIM_W){1'b0}}, req_width_reg};
                if (wr_en) req_width_next = pwdata[REQ_DIM_W-1:0];
            end
            REG_REQ_HEIGHT: begin
                prdata = {{(CFG_DATA_W-REQ_DIM_W){1'b0}}, req_height_reg};
                if (wr_en) req_height_next = pwdata[REQ_DIM_W-1:0];
            end
            REG_REQ_FORMAT: begin
                prdata = {{(CFG_DATA_W-FMT_W){1'b0}}, req_format_reg};
                if (wr_en) req_format_next = pwdata[FMT_W-1:0];
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_width_reg  <= '0;
            req_height_reg <= '0;
            req_format_reg <= '0;
        end else begin
            req_width_reg  <= req_width_next;
            req_height_reg <= req_height_next;
            req_format_reg <= req_format_next;
        end
    end

    assign cfg.req_width  = req_width_reg;
    assign cfg.req_height = req_height_reg;
    assign cfg.req_format = req_format_reg;

endmodule

FILE: rtl/core/cims_front.sv
module cims_front #(
    parameter int MAX_ENTRIES = cims_pkg::MAX_ENTRIES_DEF,
    parameter int DIM_BITS    = cims_pkg::DIM_BITS_DEF,
    parameter int ENT_W       = 3 + $clog2(MAX_ENTRIES) + 6 * DIM_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((2*DIM_BITS+7)/8)*8-1:0]      s_tdata,
    input  logic [cims_pkg::S_TUSER_W-1:0]       s_tuser,
    input  logic                                 s_tlast,
    input  cims_pkg::cims_cfg_t                  cfg,
    input  cims_pkg::cims_qstat_t                q_stat,
    output logic                                 q_push,
    output logic [ENT_W-1:0]                     q_wdata
);
    import cims_pkg::*;

    localparam int POS_W  = $clog2(MAX_ENTRIES);
    localparam int PROD_W = 2 * DIM_BITS;

    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [DIM_BITS-1:0]           ew, eh, rw, rh, min_w, min_h;
    logic [REQ_DIM_W+DIM_BITS-1:0] rw_ext, rh_ext;
    logic [PROD_W-1:0]             prod_e, prod_r, prod_o;
    cims_flags_t                   flags;

    assign ew     = s_tdata[DIM_BITS-1:0];
    assign eh     = s_tdata[2*DIM_BITS-1:DIM_BITS];
    assign rw_ext = {{DIM_BITS{1'b0}}, cfg.req_width};
    assign rh_ext = {{DIM_BITS{1'b0}}, cfg.req_height};
    assign rw     = rw_ext[DIM_BITS-1:0];
    assign rh     = rh_ext[DIM_BITS-1:0];
    assign min_w  = (rw < ew) ? rw : ew;
    assign min_h  = (rh < eh) ? rh : eh;
    assign prod_e = PROD_W'(ew) * PROD_W'(eh);
    assign prod_r = PROD_W'(rw) * PROD_W'(rh);
    assign prod_o = PROD_W'(min_w) * PROD_W'(min_h);

    assign flags.is_mode  = s_tuser[0];
    assign flags.is_match = (cfg.req_format == {1'b0, s_tuser[1]});
    assign flags.last     = s_tlast;

    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && s_tready;
    assign q_wdata  = {flags, pos_reg, prod_e, prod_r, prod_o};

    always_comb begin
        pos_next = pos_reg;
        if (q_push) begin
            if (s_tlast || pos_reg == POS_W'(MAX_ENTRIES - 1)) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: rtl/core/cims_queue.sv
module cims_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cims_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  pop,
    output logic [WIDTH-1:0]      rdata,
    output cims_pkg::cims_qstat_t stat
);
    import cims_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign rdata      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/core/cims_back.sv
module cims_back #(
    parameter int MAX_ENTRIES = cims_pkg::MAX_ENTRIES_DEF,
    parameter int DIM_BITS    = cims_pkg::DIM_BITS_DEF,
    parameter int ENT_W       = 3 + $clog2(MAX_ENTRIES) + 6 * DIM_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [ENT_W-1:0]               q_rdata,
    input  cims_pkg::cims_qstat_t          q_stat,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cims_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [cims_pkg::M_TUSER_W-1:0] m_tuser
);
    import cims_pkg::*;

    localparam int POS_W  = $clog2(MAX_ENTRIES);
    localparam int PROD_W = 2 * DIM_BITS;
    localparam int DW     = PROD_W + 1;

    cims_flags_t       flags;
    logic [POS_W-1:0]  pos;
    logic [PROD_W-1:0] prod_e, prod_r, prod_o;
    logic [DW-1:0]     dist_val;

    logic              match_valid_reg, match_valid_next;
    logic [DW-1:0]     match_dist_reg, match_dist_next;
    logic [POS_W-1:0]  match_pos_reg, match_pos_next;
    logic              other_valid_reg, other_valid_next;
    logic [DW-1:0]     other_dist_reg, other_dist_next;
    logic [POS_W-1:0]  other_pos_reg, other_pos_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic              sel_found, sel_matched;
    logic [DW-1:0]     sel_dist;
    logic [POS_W-1:0]  sel_pos;
    logic [POS_W+INDEX_W-1:0] idx_ext;
    logic [DW+DIST_OUT_W-1:0] dist_ext;

    assign {flags, pos, prod_e, prod_r, prod_o} = q_rdata;
    assign dist_val = DW'(prod_e) + DW'(prod_r) - {prod_o, 1'b0};

    assign q_pop = !q_stat.empty && (!flags.last || !m_tvalid_reg || m_tready);

    always_comb begin
        match_valid_next = match_valid_reg;
        match_dist_next  = match_dist_reg;
        match_pos_next   = match_pos_reg;
        other_valid_next = other_valid_reg;
        other_dist_next  = other_dist_reg;
        other_pos_next   = other_pos_reg;
        if (flags.is_mode) begin
            if (flags.is_match) begin
                if (!match_valid_reg || dist_val < match_dist_reg) begin
                    match_valid_next = 1'b1;
                    match_dist_next  = dist_val;
                    match_pos_next   = pos;
                end
            end else begin
                if (!other_valid_reg || dist_val < other_dist_reg) begin
                    other_valid_next = 1'b1;
                    other_dist_next  = dist_val;
                    other_pos_next   = pos;
                end
            end
        end
    end

    always_comb begin
        sel_found   = 1'b0;
        sel_matched = 1'b0;
        sel_dist    = '0;
        sel_pos     = '0;
        if (match_valid_next) begin
            sel_found   = 1'b1;
            sel_matched = 1'b1;
            sel_dist    = match_dist_next;
            sel_pos     = match_pos_next;
        end else if (other_valid_next) begin
            sel_found   = 1'b1;
            sel_dist    = other_dist_next;
            sel_pos     = other_pos_next;
        end
    end

    assign idx_ext  = {{INDEX_W{1'b0}}, sel_pos};
    assign dist_ext = {{DIST_OUT_W{1'b0}}, sel_dist};

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (q_pop && flags.last) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{(M_TDATA_W-INDEX_W-DIST_OUT_W){1'b0}},
                             dist_ext[DIST_OUT_W-1:0], idx_ext[INDEX_W-1:0]};
            m_tuser_next  = {sel_matched, sel_found};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_valid_reg <= 1'b0;
            other_valid_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (q_pop) begin
                if (flags.last) begin
                    match_valid_reg <= 1'b0;
                    other_valid_reg <= 1'b0;
                end else begin
                    match_valid_reg <= match_valid_next;
                    other_valid_reg <= other_valid_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            match_dist_reg <= match_dist_next;
            match_pos_reg  <= match_pos_next;
            other_dist_reg <= other_dist_next;
            other_pos_reg  <= other_pos_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
